/* hw/rtl/sbsh_pkg.sv */
`timescale 1ns / 1ps

package sbsh_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;

    // Last byte position of the zero fill before the length field.
    localparam logic [5:0] ZERO_END   = 6'd55;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    localparam t_word HASH_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K_ROUND [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_LEN,
        S_PRE,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath; at most one is set per cycle.
    typedef struct packed {
        logic load_byte;
        logic pad80;
        logic padz;
        logic wr_len;
        logic pre;
        logic round;
        logic add;
        logic out_shift;
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;
        logic       pp_end;
        logic       pp_last;
        logic       rnd_last;
        logic       out_last;
    } t_sts;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* hw/rtl/sbsh_in_if.sv */
`timescale 1ns / 1ps

interface sbsh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;

    modport source (output valid, output data_byte, output byte_present,
                    output message_end, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input message_end, output ready);
endinterface

/* hw/rtl/sbsh_out_if.sv */
`timescale 1ns / 1ps

interface sbsh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

/* hw/rtl/sbsh_ctrl.sv */
`timescale 1ns / 1ps

module sbsh_ctrl import sbsh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_byte_present,
    input  logic i_message_end,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid
);

    t_state r_state, n_state;
    t_state r_after, n_after;
    logic   r_ovf, n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_ovf   <= n_ovf;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_ovf       = r_ovf;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_byte = i_byte_present;
                    if (i_byte_present && i_sts.pos == BLOCK_LAST) begin
                        n_state = S_PRE;
                        n_after = i_message_end ? S_PAD80 : S_IDLE;
                    end else if (i_message_end) begin
                        n_state = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                o_cmd.pad80 = 1'b1;
                n_ovf       = 1'b0;
                if (i_sts.pos == ZERO_END) begin
                    n_state = S_LEN;
                end else if (i_sts.pos == BLOCK_LAST) begin
                    n_state = S_PRE;
                    n_after = S_PADZ;
                end else if (i_sts.pos > ZERO_END) begin
                    n_state = S_PADZ;
                    n_ovf   = 1'b1;
                end else begin
                    n_state = S_PADZ;
                end
            end
            S_PADZ: begin
                o_cmd.padz = 1'b1;
                if (r_ovf && i_sts.pp_last) begin
                    n_state = S_PRE;
                    n_after = S_PADZ;
                    n_ovf   = 1'b0;
                end else if (!r_ovf && i_sts.pp_end) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.wr_len = 1'b1;
                n_state      = S_PRE;
                n_after      = S_OUT;
            end
            S_PRE: begin
                o_cmd.pre = 1'b1;
                n_state   = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_sts.rnd_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = r_after;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.out_shift = 1'b1;
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/sbsh_dp.sv */
`timescale 1ns / 1ps

module sbsh_dp import sbsh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_data_byte,
    output t_sts        o_sts,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_word       r_h   [0:7];
    t_word       r_v   [0:7];
    t_word       r_w   [0:15];
    t_word       r_hkw;
    logic [63:0] r_len;
    logic [5:0]  r_rnd;
    logic [5:0]  r_pp;
    logic [2:0]  r_oidx;

    logic [5:0]  w_pos;
    logic [5:0]  w_rnd_nx;
    t_word       w_t1;
    t_word       w_t2;
    t_word       w_new_w;
    t_word       w_hkw_nx;

    assign w_pos    = r_len[8:3];
    assign w_rnd_nx = r_rnd + 6'd1;

    assign w_t1 = r_hkw + big_sigma1(r_v[4])
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]));
    assign w_t2 = big_sigma0(r_v[0])
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_new_w  = r_w[0] + small_sigma0(r_w[1]) + r_w[9] + small_sigma1(r_w[14]);
    // h + K + W for the following round; h then is the current g.
    assign w_hkw_nx = r_v[6] + K_ROUND[w_rnd_nx] + r_w[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h    <= HASH_INIT;
            r_len  <= '0;
            r_rnd  <= '0;
            r_pp   <= '0;
            r_oidx <= '0;
        end else begin
            if (i_cmd.load_byte) begin
                r_len <= r_len + 64'd8;
            end
            if (i_cmd.pad80) begin
                r_pp <= w_pos + 6'd1;
            end
            if (i_cmd.padz) begin
                r_pp <= r_pp + 6'd1;
            end
            if (i_cmd.pre) begin
                r_rnd <= '0;
            end
            if (i_cmd.round) begin
                r_rnd <= w_rnd_nx;
            end
            if (i_cmd.add) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.out_shift) begin
                // Shifting the initial values in behind the digest leaves the
                // hash state ready for the next message after the eighth word.
                for (int i = 0; i < 7; i++) begin
                    r_h[i] <= r_h[i+1];
                end
                r_h[7] <= HASH_INIT[r_oidx];
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == WORD_LAST) begin
                    r_len <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_w[w_pos[5:2]][(3 - w_pos[1:0]) * 8 +: 8] <= i_data_byte;
        end
        if (i_cmd.pad80) begin
            r_w[w_pos[5:2]][(3 - w_pos[1:0]) * 8 +: 8] <= PAD_BYTE;
        end
        if (i_cmd.padz) begin
            r_w[r_pp[5:2]][(3 - r_pp[1:0]) * 8 +: 8] <= 8'h00;
        end
        if (i_cmd.wr_len) begin
            r_w[14] <= r_len[63:32];
            r_w[15] <= r_len[31:0];
        end
        if (i_cmd.pre) begin
            r_v   <= r_h;
            r_hkw <= r_h[7] + K_ROUND[0] + r_w[0];
        end
        if (i_cmd.round) begin
            r_v[0] <= w_t1 + w_t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + w_t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
            r_hkw  <= w_hkw_nx;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new_w;
        end
    end

    assign o_sts.pos      = w_pos;
    assign o_sts.pp_end   = (r_pp == ZERO_END);
    assign o_sts.pp_last  = (r_pp == BLOCK_LAST);
    assign o_sts.rnd_last = (r_rnd == ROUND_LAST);
    assign o_sts.out_last = (r_oidx == WORD_LAST);

    assign o_digest_word = r_h[0];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == WORD_LAST);

endmodule

/* hw/rtl/sha256_byte_stream_hasher_top.sv */
// An item that carries a byte and does not fill the block is accepted in the idle state.
// Filling the 64th byte of a block starts a compression: setup, 64 rounds, hash update.
// End of message: the pad byte, up to 63 zero bytes, the length write, and one
// compression per block (two blocks when the pad overflows), then 8 words.
// The one-round compression core sets the rate; no item is taken during a compression.
// Synchronous active-low reset restores the initial hash and a zero length.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_top import sbsh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sbsh_in_if.sink    i_in,
    sbsh_out_if.source o_out
);

    // The controller sequences loading, padding, the length write, the rounds
    // and the digest readout; the datapath holds the message schedule window,
    // the working variables, the hash state and the bit length.
    t_cmd w_cmd;
    t_sts w_sts;

    sbsh_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .i_byte_present (i_in.byte_present),
        .i_message_end  (i_in.message_end),
        .i_out_ready    (o_out.ready),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd),
        .o_in_ready     (i_in.ready),
        .o_out_valid    (o_out.valid)
    );

    // Message bytes go straight into the 16-word schedule window, which then
    // slides one word per round to produce the expanded schedule.
    sbsh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_byte   (i_in.data_byte),
        .o_sts         (w_sts),
        .o_digest_word (o_out.digest_word),
        .o_word_index  (o_out.word_index),
        .o_last_word   (o_out.last_word)
    );

    // The controller never issues two datapath commands in one cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command at once");

    // No new item is taken while a digest is being delivered.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while digest pending");

    // Delivering the last word returns the block to accepting items.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word) |=> i_in.ready)
        else $error("block not ready after last digest word");

endmodule

/* tb/tb_sha256_byte_stream_hasher_top.sv */
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher_top;
    import sbsh_pkg::*;

    // Run length guard: far above the slowest correct run with every stall and gap
    // at its longest.
    localparam int TIMEOUT_NS = 1_000_000;

    // Cycles the digest receiver holds off in one stretch.  That is long enough
    // for a whole digest to back up and for the hasher to refuse message items.
    localparam int LONG_HOLD_CYCLES = 400;

    // Quiet cycles after the last digest word before the verdict.
    localparam int DRAIN_CYCLES = 100;

    // Random part: the first message sits on a padding boundary.  A 57-byte
    // message leaves no room for the length field after the pad byte, so the
    // padding spills into a second block.  The remaining messages are short.
    localparam int N_EDGE_MSGS   = 1;
    localparam int EDGE_LENGTHS [N_EDGE_MSGS] = '{57};
    localparam int N_RANDOM_MSGS = N_EDGE_MSGS + 6;
    localparam int N_QUIET_MSGS  = 2;

    // Digests that are well known and can be typed in directly.
    localparam logic [255:0] DIGEST_EMPTY =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] DIGEST_ABC =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    // One row of the directed table.  When has_digest is set, the digest that
    // the row's end mark produces is the typed value instead of the predicted one.
    typedef struct packed {
        logic [7:0]   data_byte;
        logic         byte_present;
        logic         message_end;
        logic         has_digest;
        logic [255:0] digest;
    } t_stim_row;

    // One digest word as it leaves the hasher.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_word;

    localparam int N_DIRECTED = 16;
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        // Empty message right after reset; the byte field is ignored.
        '{8'hff, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
        // An item with neither a byte nor an end mark changes nothing.
        '{8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
        // "abc" with the end mark on the last byte.
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
        // "abc" again, with an empty item inside and the end mark on its own.
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'ha5, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_ABC},
        // Byte extremes, checked against the predictor.
        '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h80, 1'b1, 1'b1, 1'b0, 256'h0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sbsh_in_if  msg_if ();
    sbsh_out_if dig_if ();

    sha256_byte_stream_hasher_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (msg_if),
        .o_out   (dig_if)
    );

    // 2 ns clock period.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Digest predictor: its own hash state, bit count and block buffer.
    // ------------------------------------------------------------------
    logic [31:0] hash_state [8];
    logic [63:0] msg_bits;
    logic [7:0]  block_bytes [64];

    // Words of digest still to come from the hasher, oldest first.
    t_digest_word digest_q [$];

    int  fail_count    = 0;
    bit  no_idle       = 1'b0;  // set for the closing stretch of the run
    bit  long_hold_req = 1'b0;  // asks the receiver for one long hold-off

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int unsigned n);
        logic [63:0] twin;
        twin = {x, x} >> n;
        return twin[31:0];
    endfunction

    function automatic void restart_hash();
        int i;
        for (i = 0; i < 8; i++) hash_state[i] = HASH_INIT[i];
        msg_bits = '0;
    endfunction

    // One 64-round compression of block_bytes into hash_state.
    function automatic void compress_block();
        logic [31:0] sched [64];
        logic [31:0] wv [8];
        logic [31:0] t1, t2, s0, s1;
        int r;
        for (r = 0; r < 16; r++)
            sched[r] = {block_bytes[4*r], block_bytes[4*r+1],
                        block_bytes[4*r+2], block_bytes[4*r+3]};
        for (r = 16; r < 64; r++) begin
            s0 = rot_right(sched[r-15], 7) ^ rot_right(sched[r-15], 18) ^ (sched[r-15] >> 3);
            s1 = rot_right(sched[r-2], 17) ^ rot_right(sched[r-2], 19) ^ (sched[r-2] >> 10);
            sched[r] = sched[r-16] + s0 + sched[r-7] + s1;
        end
        for (r = 0; r < 8; r++) wv[r] = hash_state[r];
        for (r = 0; r < 64; r++) begin
            t1 = wv[7] + (rot_right(wv[4], 6) ^ rot_right(wv[4], 11) ^ rot_right(wv[4], 25))
               + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + K_ROUND[r] + sched[r];
            t2 = (rot_right(wv[0], 2) ^ rot_right(wv[0], 13) ^ rot_right(wv[0], 22))
               + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
            wv[7] = wv[6];
            wv[6] = wv[5];
            wv[5] = wv[4];
            wv[4] = wv[3] + t1;
            wv[3] = wv[2];
            wv[2] = wv[1];
            wv[1] = wv[0];
            wv[0] = t1 + t2;
        end
        for (r = 0; r < 8; r++) hash_state[r] = hash_state[r] + wv[r];
    endfunction

    // Takes one message item.  Returns 1 with the finished digest when the item
    // ends the message, and then starts the next message from the initial hash.
    function automatic bit absorb_item(input logic [7:0] data_byte, input logic byte_present,
                                       input logic message_end, output logic [255:0] digest);
        int pos;
        int i;
        digest = '0;
        if (byte_present) begin
            pos = int'(msg_bits[8:3]);
            block_bytes[pos] = data_byte;
            msg_bits = msg_bits + 64'd8;
            if (pos == BLOCK_BYTES - 1) compress_block();
        end
        if (!message_end) return 1'b0;

        // Padding: the 0x80 marker, zeros, then the bit count big-endian in the
        // last 8 bytes.  If the marker leaves no room for the count, the zeros
        // run to the end of this block and the count goes into one more block.
        pos = int'(msg_bits[8:3]);
        block_bytes[pos] = PAD_BYTE;
        pos++;
        if (pos > BLOCK_BYTES - 8) begin
            while (pos < BLOCK_BYTES) begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < BLOCK_BYTES - 8) begin
            block_bytes[pos] = 8'h00;
            pos++;
        end
        for (i = 0; i < 8; i++) block_bytes[BLOCK_BYTES - 8 + i] = msg_bits[8*(7-i) +: 8];
        compress_block();

        for (i = 0; i < 8; i++) digest[255 - 32*i -: 32] = hash_state[i];
        restart_hash();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Message sender.  Offers one item, waits for its handshake, and on
    // acceptance queues the eight digest words that the item brings about.
    // Random gaps come before some items, except in the closing stretch.
    // ------------------------------------------------------------------
    task automatic offer_item(input logic [7:0] data_byte, input logic byte_present,
                              input logic message_end, input logic has_digest,
                              input logic [255:0] typed_digest);
        logic [255:0] digest;
        int w;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            msg_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        msg_if.valid        <= 1'b1;
        msg_if.data_byte    <= data_byte;
        msg_if.byte_present <= byte_present;
        msg_if.message_end  <= message_end;
        @(posedge clk);
        while (msg_if.ready !== 1'b1) @(posedge clk);

        if (absorb_item(data_byte, byte_present, message_end, digest)) begin
            if (has_digest) digest = typed_digest;
            for (w = 0; w < 8; w++)
                digest_q.push_back('{digest[255 - 32*w -: 32], 3'(w), 3'(w) == WORD_LAST});
        end
    endtask

    // ------------------------------------------------------------------
    // Digest receiver.  Ready drops in random bursts, once for a long stretch
    // on request, and never in the closing stretch.
    // One assignment to ready per clock edge.
    // ------------------------------------------------------------------
    initial begin : digest_receiver
        int hold_left;
        hold_left = 0;
        dig_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                dig_if.ready <= 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                dig_if.ready <= 1'b0;
                hold_left = LONG_HOLD_CYCLES - 1;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                dig_if.ready <= 1'b0;
                hold_left = $urandom_range(0, 8);
            end else begin
                dig_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Digest checker: every accepted word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : digest_checker
        t_digest_word want;
        if (rst_n && dig_if.valid === 1'b1 && dig_if.ready === 1'b1) begin
            if (digest_q.size() == 0) begin
                $error("digest word %h (index %0d) arrived with none expected",
                       dig_if.digest_word, dig_if.word_index);
                fail_count++;
            end else begin
                want = digest_q.pop_front();
                if (dig_if.digest_word !== want.digest_word) begin
                    $error("digest_word: expected %h, got %h",
                           want.digest_word, dig_if.digest_word);
                    fail_count++;
                end
                if (dig_if.word_index !== want.word_index) begin
                    $error("word_index: expected %0d, got %0d",
                           want.word_index, dig_if.word_index);
                    fail_count++;
                end
                if (dig_if.last_word !== want.last_word) begin
                    $error("last_word: expected %0b, got %0b",
                           want.last_word, dig_if.last_word);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random messages, drain, verdict.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int row;
        int m;
        int k;
        int len;
        bit end_on_byte;

        msg_if.valid        <= 1'b0;
        msg_if.data_byte    <= 8'h00;
        msg_if.byte_present <= 1'b0;
        msg_if.message_end  <= 1'b0;
        restart_hash();

        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty messages, an item that does nothing, "abc" with
        // the end mark on a byte and on an empty item, and the byte extremes.
        for (row = 0; row < N_DIRECTED; row++)
            offer_item(DIRECTED_ROWS[row].data_byte, DIRECTED_ROWS[row].byte_present,
                       DIRECTED_ROWS[row].message_end, DIRECTED_ROWS[row].has_digest,
                       DIRECTED_ROWS[row].digest);

        // The sender pauses here until every digest of the directed part is in.
        msg_if.valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk);
        @(posedge clk);

        // Random messages.  Random bytes cover every bit of the byte field; a
        // message ends either on its last byte or on a separate empty item, and
        // now and then an empty item without an end mark slips in as noise.
        for (m = 0; m < N_RANDOM_MSGS; m++) begin
            if (m == N_RANDOM_MSGS - N_QUIET_MSGS) no_idle = 1'b1;
            len = (m < N_EDGE_MSGS) ? EDGE_LENGTHS[m] : $urandom_range(0, 8);
            end_on_byte = ($urandom_range(0, 1) == 1);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                offer_item(8'($urandom_range(0, 255)), 1'b1,
                           end_on_byte && (k == len - 1), 1'b0, '0);
            end
            if (len == 0 || !end_on_byte)
                offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);

            // Once the first long message has ended, the receiver holds off for
            // a long stretch while the sender keeps offering the next message,
            // so the digest backs up and the hasher stops taking items.
            if (m == 0) long_hold_req = 1'b1;
        end
        msg_if.valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && digest_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop if the hasher hangs.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/sbsh_pkg.sv
hw/rtl/sbsh_in_if.sv
hw/rtl/sbsh_out_if.sv
hw/rtl/sbsh_ctrl.sv
hw/rtl/sbsh_dp.sv
hw/rtl/sha256_byte_stream_hasher_top.sv
tb/tb_sha256_byte_stream_hasher_top.sv
